/* design/mste_pkg.sv */
// Package: function codes, controller commands and shared constants.
`default_nettype none
package mste_pkg;
  localparam logic [2:0] FUNC_WR_MEM = 3'd0;
  localparam logic [2:0] FUNC_RD_MEM = 3'd1;
  localparam logic [2:0] FUNC_WR_REG = 3'd2;
  localparam logic [2:0] FUNC_RD_REG = 3'd3;
  localparam logic [2:0] FUNC_SET_PC = 3'd4;
  localparam logic [2:0] FUNC_SWAP   = 3'd5;
  localparam logic [2:0] FUNC_TAS    = 3'd6;
  localparam logic [2:0] FUNC_SVS    = 3'd7;

  localparam logic [7:0] MODE_MASK  = 8'h38;
  localparam logic [7:0] REG_MASK   = 8'h07;
  localparam logic [7:0] IDX_AREG   = 8'h80;
  localparam logic [7:0] IDX_SEL    = 8'h70;
  localparam logic [7:0] IDX_LONG   = 8'h08;
  localparam logic [7:0] BYTE_ONES  = 8'hff;

  // Datapath operation selected by the controller for the current cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,     // capture input beat
    OP_DEBUG,     // perform debug function
    OP_MEM_REQ,   // issue memory read at the fetch pointer
    OP_GET_OPW,   // take opcode low byte
    OP_GET_EXT,   // shift in an extension byte
    OP_SWAP,
    OP_EA,        // form effective address
    OP_OPND_REQ,  // issue operand read
    OP_EXEC,      // modify operand, write back
    OP_ILLEGAL
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic [2:0] mode;
    logic [2:0] rsel;
    logic       illegal;
    logic [2:0] ext_need;  // extension bytes still to fetch
  } stat_t;
endpackage
`default_nettype wire

/* design/mste_datapath.sv */
// Datapath: register file, PC, flags, byte memory and effective address logic.
`default_nettype none
module mste_datapath #(
  parameter int MemAddrBits = 16
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  mste_pkg::cmd_t     cmd_i,
  output mste_pkg::stat_t    stat_o,
  input  wire  [2:0]         func_i,
  input  wire  [15:0]        mem_address_i,
  input  wire  [3:0]         reg_index_i,
  input  wire  [31:0]        write_value_i,
  input  wire  [3:0]         flags_in_i,
  output logic [31:0]        read_value_o,
  output logic [31:0]        effective_address_o,
  output logic [31:0]        pc_out_o,
  output logic [3:0]         flags_out_o,
  output logic               status_o
);
  import mste_pkg::*;

  logic [7:0]  mem_q [2**MemAddrBits];
  logic [7:0]  mrd_q;
  logic [31:0] dreg_q [8];
  logic [31:0] areg_q [8];
  logic [31:0] pc_q, fptr_q, ext_q, ea_q;
  logic [3:0]  flg_q;
  logic [2:0]  func_q, mode_q, rsel_q, ext_need_q;
  logic [15:0] addr_q;
  logic [3:0]  ridx_q;
  logic [31:0] wv_q;
  logic [3:0]  fin_q;
  logic [7:0]  xbyte_q;
  logic        rdm_q;

  logic                   mem_we;
  logic [MemAddrBits-1:0] mem_wa, mem_ra;
  logic [7:0]             mem_wd;

  logic [2:0] md;
  logic       ill;
  assign md  = 3'((mrd_q & MODE_MASK) >> 3);
  assign ill = (md == 3'd1) || (md == 3'd7 && (mrd_q[2:0] > 3'd1));

  assign stat_o = '{func: func_q, mode: mode_q, rsel: rsel_q,
                    illegal: ill, ext_need: ext_need_q};

  logic [31:0] swp, idx, opnd;
  logic [7:0]  ob, nb;
  logic [2:0]  isel;
  always_comb begin
    swp  = {dreg_q[mrd_q[2:0]][15:0], dreg_q[mrd_q[2:0]][31:16]};
    isel = 3'((xbyte_q & IDX_SEL) >> 4);
    idx  = ((xbyte_q & IDX_AREG) != 8'h0) ? areg_q[isel] : dreg_q[isel];
    if ((xbyte_q & IDX_LONG) == 8'h0) idx = {16'h0, idx[15:0]};
    opnd = {24'h0, (mode_q == 3'd0) ? dreg_q[ea_q[2:0]][7:0] : mrd_q};
    ob   = opnd[7:0];
    nb   = (func_q == FUNC_TAS) ? (ob | IDX_AREG) :
           (flg_q[1] ? BYTE_ONES : 8'h00);
    mem_we = 1'b0;
    mem_wa = MemAddrBits'(addr_q);
    mem_wd = wv_q[7:0];
    mem_ra = fptr_q[MemAddrBits-1:0];
    unique case (cmd_i.op)
      OP_DEBUG:    mem_we = (func_q == FUNC_WR_MEM);
      OP_EXEC: begin
        mem_we = (mode_q != 3'd0);
        mem_wa = ea_q[MemAddrBits-1:0];
        mem_wd = nb;
      end
      OP_OPND_REQ: mem_ra = ea_q[MemAddrBits-1:0];
      default: ;
    endcase
    if (cmd_i.op == OP_DEBUG) mem_ra = MemAddrBits'(addr_q);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    mrd_q <= mem_q[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        dreg_q[i] <= '0;
        areg_q[i] <= '0;
      end
      pc_q <= '0;
      flg_q <= '0;
      func_q <= '0; mode_q <= '0; rsel_q <= '0; ext_need_q <= '0;
      fptr_q <= '0;
      addr_q <= '0; ridx_q <= '0; wv_q <= '0; fin_q <= '0;
      ext_q <= '0; ea_q <= '0; xbyte_q <= '0;
      read_value_o <= '0; effective_address_o <= '0; status_o <= 1'b0;
    end else begin
      unique case (cmd_i.op)
        OP_LATCH: begin
          func_q <= func_i; addr_q <= mem_address_i; ridx_q <= reg_index_i;
          wv_q <= write_value_i; fin_q <= flags_in_i;
          fptr_q <= pc_q + 32'd1;
          read_value_o <= '0; effective_address_o <= '0; status_o <= 1'b0;
        end
        OP_DEBUG: begin
          unique case (func_q)
            FUNC_WR_REG:
              if (!ridx_q[3]) dreg_q[ridx_q[2:0]] <= wv_q;
              else areg_q[ridx_q[2:0]] <= wv_q;
            FUNC_RD_REG:
              read_value_o <= ridx_q[3] ? areg_q[ridx_q[2:0]] : dreg_q[ridx_q[2:0]];
            FUNC_SET_PC: begin pc_q <= wv_q; flg_q <= fin_q; end
            default: ;
          endcase
        end
        OP_GET_OPW: begin
          mode_q <= md; rsel_q <= mrd_q[2:0]; ext_q <= '0;
          fptr_q <= fptr_q + 32'd1;
          unique case (md)
            3'd5:    ext_need_q <= 3'd2;
            3'd6:    ext_need_q <= 3'd2;
            3'd7:    ext_need_q <= mrd_q[0] ? 3'd4 : 3'd2;
            default: ext_need_q <= 3'd0;
          endcase
        end
        OP_GET_EXT: begin
          if (mode_q == 3'd6 && ext_need_q == 3'd2) xbyte_q <= mrd_q;
          ext_q <= {ext_q[23:0], mrd_q};
          ext_need_q <= ext_need_q - 3'd1;
          fptr_q <= fptr_q + 32'd1;
        end
        OP_SWAP: begin
          dreg_q[mrd_q[2:0]] <= swp;
          flg_q <= {swp[31], swp == 32'h0, 2'b00};
          pc_q <= pc_q + 32'd2;
          read_value_o <= swp;
          effective_address_o <= {29'h0, mrd_q[2:0]};
        end
        OP_EA: begin
          pc_q <= fptr_q;
          unique case (mode_q)
            3'd0: ea_q <= {29'h0, rsel_q};
            3'd2: ea_q <= areg_q[rsel_q];
            3'd3: begin
              ea_q <= areg_q[rsel_q];
              areg_q[rsel_q] <= areg_q[rsel_q] + 32'd1;
            end
            3'd4: begin
              ea_q <= areg_q[rsel_q] - 32'd1;
              areg_q[rsel_q] <= areg_q[rsel_q] - 32'd1;
            end
            3'd5: ea_q <= areg_q[rsel_q] + {16'h0, ext_q[15:0]};
            3'd6: ea_q <= areg_q[rsel_q] + idx + {24'h0, ext_q[7:0]};
            default: ea_q <= ext_q;
          endcase
        end
        OP_EXEC: begin
          if (mode_q == 3'd0) dreg_q[ea_q[2:0]][7:0] <= nb;
          if (func_q == FUNC_TAS) flg_q <= {ob[7], ob == 8'h0, 2'b00};
          read_value_o <= {24'h0, nb};
          effective_address_o <= ea_q;
        end
        OP_ILLEGAL: status_o <= 1'b1;
        default: ;
      endcase
      // memory read data is captured in the cycle after the debug command
      if (rdm_q) read_value_o <= {24'h0, mrd_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rdm_q <= 1'b0;
    else rdm_q <= (cmd_i.op == OP_DEBUG) && (func_q == FUNC_RD_MEM);
  end
  assign pc_out_o    = pc_q;
  assign flags_out_o = flg_q;

`ifndef SYNTHESIS
  a_ext_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ext_need_q <= 3'd4) else $error("extension count out of range");
  a_swap_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_SWAP |=> flg_q[1:0] == 2'b00) else $error("swap flags");
  a_tas_bit7: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_EXEC && func_q == FUNC_TAS) |=> read_value_o[7])
    else $error("tas bit 7 not set");
`endif
endmodule
`default_nettype wire

/* design/mste_ctrl.sv */
// Controller: sequences fetch, address decode, operand access and handshake.
`default_nettype none
module mste_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  input  mste_pkg::stat_t  stat_i,
  output mste_pkg::cmd_t   cmd_o
);
  import mste_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DISP  = 9'b000000010,
    S_OPW   = 9'b000000100,
    S_EXTR  = 9'b000001000,
    S_EXT   = 9'b000010000,
    S_EA    = 9'b000100000,
    S_OPR   = 9'b001000000,
    S_EXEC  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   dbg_wait_q, dbg_wait_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT) && !dbg_wait_q;

  always_comb begin
    state_d = state_q;
    dbg_wait_d = 1'b0;
    cmd_o.op = OP_NONE;
    unique case (state_q)
      S_IDLE: if (in_valid_i) begin
        cmd_o.op = OP_LATCH;
        state_d = S_DISP;
      end
      S_DISP: begin
        // debug functions finish at once, execute items fetch the opcode byte
        if (stat_i.func <= FUNC_SET_PC) begin
          cmd_o.op = OP_DEBUG;
          state_d = S_OUT;
          dbg_wait_d = 1'b1;
        end else begin
          cmd_o.op = OP_MEM_REQ;
          state_d = S_OPW;
        end
      end
      S_OPW: begin
        if (stat_i.func == FUNC_SWAP) begin
          cmd_o.op = OP_SWAP;
          state_d = S_OUT;
        end else if (stat_i.illegal) begin
          cmd_o.op = OP_ILLEGAL;
          state_d = S_OUT;
        end else begin
          cmd_o.op = OP_GET_OPW;
          state_d = S_EXTR;
        end
      end
      S_EXTR: begin
        cmd_o.op = OP_MEM_REQ;
        state_d = (stat_i.ext_need != 3'd0) ? S_EXT : S_EA;
      end
      S_EXT: begin
        cmd_o.op = OP_GET_EXT;
        state_d = S_EXTR;
      end
      S_EA: begin
        cmd_o.op = OP_EA;
        state_d = S_OPR;
      end
      S_OPR: begin
        cmd_o.op = OP_OPND_REQ;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.op = OP_EXEC;
        state_d = S_OUT;
      end
      S_OUT: if (out_valid_o && out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      dbg_wait_q <= 1'b0;
    end else begin
      state_q <= state_d;
      dbg_wait_q <= dbg_wait_d;
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !in_ready_o) else $error("ready while busy");
  a_out_after_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i) |=> state_q == S_IDLE) else $error("no return to idle");
  a_exec_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXEC |=> state_q == S_OUT) else $error("exec not followed by result");
`endif
endmodule
`default_nettype wire

/* design/m68k_swap_tas_svs_execute_top.sv */
// One item in flight: a new item is accepted only after the previous result has been
// taken. Opcode and extension bytes are fetched one at a time over the single memory
// read port. Reset clears registers, PC, flags and the controller; memory contents
// stay undefined until written.
`default_nettype none
module m68k_swap_tas_svs_execute_top #(
  parameter int MEM_ADDR_BITS = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [2:0]  func_i,
  input  wire  [15:0] mem_address_i,
  input  wire  [3:0]  reg_index_i,
  input  wire  [31:0] write_value_i,
  input  wire  [3:0]  flags_in_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [31:0] read_value_o,
  output logic [31:0] effective_address_o,
  output logic [31:0] pc_out_o,
  output logic [3:0]  flags_out_o,
  output logic        status_o
);
  import mste_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  mste_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .stat_i(stat), .cmd_o(cmd)
  );

  mste_datapath #(.MemAddrBits(MEM_ADDR_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .func_i, .mem_address_i, .reg_index_i, .write_value_i, .flags_in_i,
    .read_value_o, .effective_address_o, .pc_out_o, .flags_out_o,
    .status_o
  );
endmodule
`default_nettype wire

/* tb/mste_scoreboard.sv */
// Scoreboard: predicts the machine state per input beat and checks each result beat.
`timescale 1ns / 1ps
module mste_scoreboard (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  input  wire         in_ready_i,
  input  wire  [2:0]  func_i,
  input  wire  [15:0] mem_address_i,
  input  wire  [3:0]  reg_index_i,
  input  wire  [31:0] write_value_i,
  input  wire  [3:0]  flags_in_i,
  input  wire         out_valid_i,
  input  wire         out_ready_i,
  input  wire  [31:0] read_value_i,
  input  wire  [31:0] effective_address_i,
  input  wire  [31:0] pc_out_i,
  input  wire  [3:0]  flags_out_i,
  input  wire         status_i,
  output int          mismatches_o,
  output int          outstanding_o
);
  import mste_pkg::*;

  typedef struct packed {
    logic [31:0] rd_val;
    logic [31:0] ea;
    logic [31:0] pc;
    logic [3:0]  flags;
    logic        illegal;
  } result_t;

  logic [31:0] dreg [8];
  logic [31:0] areg [8];
  logic [31:0] pc_q;
  logic [3:0]  flags_q;
  logic [7:0]  mem  [65536];
  result_t     expected_q [$];

  assign outstanding_o = expected_q.size();

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp_v);
    $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, exp_v);
    mismatches_o++;
  endtask

  function automatic result_t execute_item(input logic [2:0] f, input logic [15:0] a,
                                           input logic [3:0] ri, input logic [31:0] wv,
                                           input logic [3:0] fi);
    result_t     res;
    logic [31:0] p, e, d, ix, v;
    logic [7:0]  pat, ext, b;
    logic [2:0]  m, r;
    res = '0;
    case (f)
      FUNC_WR_MEM: mem[a] = wv[7:0];
      FUNC_RD_MEM: res.rd_val = {24'h0, mem[a]};
      FUNC_WR_REG: if (ri[3]) areg[ri[2:0]] = wv; else dreg[ri[2:0]] = wv;
      FUNC_RD_REG: res.rd_val = ri[3] ? areg[ri[2:0]] : dreg[ri[2:0]];
      FUNC_SET_PC: begin
        pc_q    = wv;
        flags_q = fi;
      end
      FUNC_SWAP: begin
        p = pc_q + 32'd1;
        r = mem[p[15:0]][2:0];
        v = {dreg[r][15:0], dreg[r][31:16]};
        dreg[r] = v;
        flags_q = {v[31], v == 32'd0, 2'b00};
        pc_q = pc_q + 32'd2;
        res.rd_val = v;
        res.ea = {29'd0, r};
      end
      default: begin
        p = pc_q + 32'd1;
        pat = mem[p[15:0]];
        m = pat[5:3];
        r = pat[2:0];
        if (m == 3'd1 || (m == 3'd7 && r > 3'd1)) begin
          res.illegal = 1'b1;
        end else begin
          case (m)
            3'd0: e = {29'd0, r};
            3'd2: e = areg[r];
            3'd3: begin
              e = areg[r];
              areg[r] = areg[r] + 32'd1;
            end
            3'd4: begin
              areg[r] = areg[r] - 32'd1;
              e = areg[r];
            end
            3'd5: begin
              d = {16'd0, mem[16'(p + 32'd1)], mem[16'(p + 32'd2)]};
              e = areg[r] + d;
              p = p + 32'd2;
            end
            3'd6: begin
              ext = mem[16'(p + 32'd1)];
              ix = ext[7] ? areg[ext[6:4]] : dreg[ext[6:4]];
              if (!ext[3]) ix = ix & 32'h0000_ffff;
              e = areg[r] + ix + {24'd0, mem[16'(p + 32'd2)]};
              p = p + 32'd2;
            end
            default: begin
              d = {16'd0, mem[16'(p + 32'd1)], mem[16'(p + 32'd2)]};
              p = p + 32'd2;
              if (r == 3'd1) begin
                d = {d[15:0], mem[16'(p + 32'd1)], mem[16'(p + 32'd2)]};
                p = p + 32'd2;
              end
              e = d;
            end
          endcase
          pc_q = p + 32'd1;
          b = (m == 3'd0) ? dreg[e[2:0]][7:0] : mem[e[15:0]];
          if (f == FUNC_TAS) begin
            flags_q = {b[7], b == 8'd0, 2'b00};
            b[7] = 1'b1;
          end else begin
            b = flags_q[1] ? BYTE_ONES : 8'h00;
          end
          if (m == 3'd0) dreg[e[2:0]][7:0] = b;
          else mem[e[15:0]] = b;
          res.rd_val = {24'd0, b};
          res.ea = e;
        end
      end
    endcase
    res.pc = pc_q;
    res.flags = flags_q;
    return res;
  endfunction

  initial mismatches_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      for (int k = 0; k < 8; k++) begin
        dreg[k] = '0;
        areg[k] = '0;
      end
      pc_q = '0;
      flags_q = '0;
      expected_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          report("unexpected result beat", read_value_i, 32'd0);
        end else begin
          want = expected_q.pop_front();
          if (read_value_i !== want.rd_val) report("read_value", read_value_i, want.rd_val);
          if (effective_address_i !== want.ea)
            report("effective_address", effective_address_i, want.ea);
          if (pc_out_i !== want.pc) report("pc_out", pc_out_i, want.pc);
          if (flags_out_i !== want.flags)
            report("flags_out", {28'd0, flags_out_i}, {28'd0, want.flags});
          if (status_i !== want.illegal)
            report("status", {31'd0, status_i}, {31'd0, want.illegal});
        end
      end
      if (in_valid_i && in_ready_i)
        expected_q.push_back(execute_item(func_i, mem_address_i, reg_index_i,
                                          write_value_i, flags_in_i));
    end
  end

endmodule

/* tb/m68k_swap_tas_svs_execute_top_tb.sv */
// Testbench top: clock, reset, stimulus for SWAP/TAS/SVS and debug beats, and the verdict.
`timescale 1ns / 1ps
module m68k_swap_tas_svs_execute_top_tb;
  import mste_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready_o;
  logic [2:0]  func = FUNC_WR_MEM;
  logic [15:0] mem_address = '0;
  logic [3:0]  reg_index = '0;
  logic [31:0] write_value = '0;
  logic [3:0]  flags_in = '0;
  logic        out_valid_o;
  logic        out_ready = 1'b0;
  logic [31:0] read_value_o, effective_address_o, pc_out_o;
  logic [3:0]  flags_out_o;
  logic        status_o;
  int          mismatches, outstanding;

  int          beats_sent = 0;
  bit          quiet = 1'b0;
  int          hold_reqs = 0;
  int          holds_done = 0;
  bit          written [65536];
  logic [15:0] written_list [$];

  m68k_swap_tas_svs_execute_top i_dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o,
    .func_i(func), .mem_address_i(mem_address), .reg_index_i(reg_index),
    .write_value_i(write_value), .flags_in_i(flags_in),
    .out_valid_o, .out_ready_i(out_ready),
    .read_value_o, .effective_address_o, .pc_out_o, .flags_out_o, .status_o
  );

  mste_scoreboard i_scoreboard (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready_o),
    .func_i(func), .mem_address_i(mem_address), .reg_index_i(reg_index),
    .write_value_i(write_value), .flags_in_i(flags_in),
    .out_valid_i(out_valid_o), .out_ready_i(out_ready),
    .read_value_i(read_value_o), .effective_address_i(effective_address_o),
    .pc_out_i(pc_out_o), .flags_out_i(flags_out_o), .status_i(status_o),
    .mismatches_o(mismatches), .outstanding_o(outstanding)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("** m68k_swap_tas_svs_execute_top: FAILED **");
    $finish;
  end

  // result side: random stalls, with an occasional long hold-off
  initial begin
    int unsigned n;
    @(posedge rst_ni);
    forever begin
      n = quiet ? 0 : $urandom_range(0, 10);
      if (holds_done < hold_reqs) begin
        n = 150;
        holds_done++;
      end
      @(negedge clk_i);
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(negedge clk_i);
      end
      out_ready <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  task automatic send(input logic [2:0] f, input logic [15:0] a, input logic [3:0] ri,
                      input logic [31:0] wv, input logic [3:0] fi);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 10);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid    <= 1'b1;
    func        <= f;
    mem_address <= a;
    reg_index   <= ri;
    write_value <= wv;
    flags_in    <= fi;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    beats_sent++;
    if (f == FUNC_WR_MEM && !written[a]) begin
      written[a] = 1'b1;
      written_list.push_back(a);
    end
  endtask

  task automatic poke(input logic [31:0] a, input logic [7:0] v);
    send(FUNC_WR_MEM, a[15:0], 4'($urandom), {24'($urandom), v}, 4'($urandom));
  endtask

  // Build one instruction in memory around a fresh PC and run it. opv forces the
  // operand byte (or the data register for SWAP and register direct); -1 = random.
  task automatic run_instr(input logic [2:0] f, input logic [2:0] m, input logic [2:0] r,
                           input longint opv);
    logic [31:0] pc, base, ix, e, dv;
    logic [7:0]  code [6];
    int          len;
    bit          bad;
    pc = $urandom;
    if ($urandom_range(0, 7) == 0) pc[15:0] = 16'hfffe;
    send(FUNC_SET_PC, 16'($urandom), 4'($urandom), pc, 4'($urandom));
    code[0] = 8'($urandom);
    code[1] = {2'($urandom), m, r};
    for (int k = 2; k < 6; k++) code[k] = 8'($urandom);
    bad = (f != FUNC_SWAP) && (m == 3'd1 || (m == 3'd7 && r > 3'd1));
    dv = (opv >= 0) ? 32'(opv) : $urandom;
    len = 2;
    if (f == FUNC_SWAP || (!bad && m == 3'd0)) begin
      send(FUNC_WR_REG, 16'($urandom), {1'b0, r}, dv, 4'($urandom));
    end else if (!bad) begin
      base = $urandom;
      if (m != 3'd7) send(FUNC_WR_REG, 16'($urandom), {1'b1, r}, base, 4'($urandom));
      case (m)
        3'd4: e = base - 32'd1;
        3'd5: begin
          e = base + {16'd0, code[2], code[3]};
          len = 4;
        end
        3'd6: begin
          ix = $urandom;
          send(FUNC_WR_REG, 16'($urandom), code[2][7:4], ix, 4'($urandom));
          if (code[2][7] && code[2][6:4] == r) base = ix;
          if (!code[2][3]) ix = ix & 32'h0000_ffff;
          e = base + ix + {24'd0, code[3]};
          len = 4;
        end
        3'd7: begin
          e = (r == 3'd1) ? {code[2], code[3], code[4], code[5]} : {16'd0, code[2], code[3]};
          len = (r == 3'd1) ? 6 : 4;
        end
        default: e = base;
      endcase
      poke(e, (opv >= 0) ? 8'(opv) : 8'($urandom));
    end
    for (int k = 0; k < len; k++) poke(pc + k, code[k]);
    send(f, 16'($urandom), 4'($urandom), $urandom, 4'($urandom));
  endtask

  task automatic random_debug();
    int unsigned sel;
    sel = $urandom_range(0, 4);
    case (sel)
      0: send(FUNC_WR_MEM, 16'($urandom), 4'($urandom), $urandom, 4'($urandom));
      1: if (written_list.size() > 0)
           send(FUNC_RD_MEM, written_list[$urandom_range(0, written_list.size() - 1)],
                4'($urandom), $urandom, 4'($urandom));
      2: send(FUNC_WR_REG, 16'($urandom), 4'($urandom), $urandom, 4'($urandom));
      3: send(FUNC_RD_REG, 16'($urandom), 4'($urandom), $urandom, 4'($urandom));
      default: send(FUNC_SET_PC, 16'($urandom), 4'($urandom), $urandom, 4'($urandom));
    endcase
  endtask

  initial begin
    logic [2:0] f, m, r;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, every mode, flag corner cases, illegal forms
    send(FUNC_WR_MEM, 16'h0000, 4'h0, 32'hffff_ffff, 4'h0);
    send(FUNC_WR_MEM, 16'hffff, 4'hf, 32'h0000_0000, 4'hf);
    send(FUNC_RD_MEM, 16'h0000, 4'h0, 32'h0, 4'h0);
    send(FUNC_RD_MEM, 16'hffff, 4'h0, 32'h0, 4'h0);
    send(FUNC_WR_REG, 16'h0, 4'h0, 32'hffff_ffff, 4'h0);
    send(FUNC_WR_REG, 16'h0, 4'hf, 32'hffff_ffff, 4'h0);
    send(FUNC_RD_REG, 16'h0, 4'h0, 32'h0, 4'h0);
    send(FUNC_RD_REG, 16'h0, 4'hf, 32'h0, 4'h0);
    send(FUNC_SET_PC, 16'h0, 4'h0, 32'hffff_ffff, 4'hf);
    run_instr(FUNC_SWAP, 3'd0, 3'd3, 0);
    run_instr(FUNC_SWAP, 3'd5, 3'd7, 32'h0000_8000);
    run_instr(FUNC_TAS, 3'd0, 3'd1, 32'h0000_0080);
    run_instr(FUNC_TAS, 3'd2, 3'd0, 0);
    run_instr(FUNC_TAS, 3'd3, 3'd7, 8'h80);
    run_instr(FUNC_SVS, 3'd4, 3'd2, -1);
    run_instr(FUNC_TAS, 3'd5, 3'd4, -1);
    run_instr(FUNC_SVS, 3'd6, 3'd5, -1);
    run_instr(FUNC_TAS, 3'd7, 3'd0, -1);
    run_instr(FUNC_SVS, 3'd7, 3'd1, -1);
    run_instr(FUNC_TAS, 3'd1, 3'd6, -1);
    run_instr(FUNC_SVS, 3'd7, 3'd3, -1);

    while (beats_sent < 450) begin
      if ($urandom_range(0, 39) == 0) quiet = !quiet;
      if (beats_sent > 200 && hold_reqs == 0) hold_reqs = 1;
      if (beats_sent > 320 && hold_reqs == 1) begin
        // drop valid and pause the sender until the block has drained
        @(negedge clk_i);
        in_valid <= 1'b0;
        while (outstanding != 0) @(posedge clk_i);
        hold_reqs = 2;
      end
      if ($urandom_range(0, 9) < 7) begin
        f = 3'($urandom_range(FUNC_SWAP, FUNC_SVS));
        m = 3'($urandom);
        r = 3'($urandom);
        // keep illegal forms rare
        if ((m == 3'd1 || (m == 3'd7 && r > 3'd1)) && $urandom_range(0, 3) != 0)
          m = 3'($urandom_range(2, 6));
        run_instr(f, m, r, -1);
      end else begin
        random_debug();
      end
    end

    @(negedge clk_i);
    in_valid <= 1'b0;
    while (outstanding != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** m68k_swap_tas_svs_execute_top: PASSED **");
    end else begin
      $display("** m68k_swap_tas_svs_execute_top: FAILED **");
    end
    $finish;
  end

endmodule
